@@ sv/tblt_pkg.sv @@
// ----------------------------------------------------------------------------
// tblt_pkg
// Shared types, codes and widths of the timed block list table.
// ----------------------------------------------------------------------------
package tblt_pkg;

    // Table depth default and fixed field widths
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int FUNC_W          = 2;
    localparam int ID_W            = 64;
    localparam int DUR_W           = 32;
    localparam int TIME_W          = 31;
    localparam int STAT_W          = 2;
    localparam int ENT_W           = 7;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_BAN   = 2'd0,
        FUNC_UNBAN = 2'd1,
        FUNC_QUERY = 2'd2
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Table read address source
    typedef enum logic {
        RD_IDX  = 1'b0,
        RD_LAST = 1'b1
    } t_rd_sel;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_P_RD,
        S_P_CHK,
        S_P_MVRD,
        S_P_MVWR,
        S_S_RD,
        S_S_CHK,
        S_S_END,
        S_W_NEW,
        S_U_RD,
        S_U_WR,
        S_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_move;
        logic    wr_new;
        logic    count_inc;
        logic    count_dec;
        logic    hit_capture;
        logic    set_code;
        t_status code;
        logic    banned;
        logic    out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              in_valid;
        logic              out_free;
        logic              arg_bad;
        logic              idx_end;
        logic              expired;
        logic              match;
        logic              hit;
        logic              full;
        logic              empty;
    } t_stat;

endpackage

@@ sv/tblt_if.sv @@
// ----------------------------------------------------------------------------
// tblt_item_if / tblt_result_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface tblt_item_if
    import tblt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [ID_W-1:0]          ident;
    logic signed [DUR_W-1:0]  duration;
    logic [TIME_W-1:0]        now;

    modport source (output valid, func, ident, duration, now, input ready);
    modport sink   (input valid, func, ident, duration, now, output ready);
endinterface

interface tblt_result_if
    import tblt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              banned;
    logic [ENT_W-1:0]  entries;

    modport source (output valid, status, banned, entries, input ready);
    modport sink   (input valid, status, banned, entries, output ready);
endinterface

@@ sv/tblt_dp.sv @@
// ----------------------------------------------------------------------------
// tblt_dp
// Datapath: item registers, entry memory, walk index, entry count and the
// result register.
// ----------------------------------------------------------------------------
module tblt_dp
    import tblt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tblt_item_if.sink          i_item,
    tblt_result_if.source      o_result,
    input  t_cmd               i_cmd,
    output t_stat              o_stat
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Captured item
    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_ident;
    logic [DUR_W-1:0]  r_dur;
    logic [TIME_W-1:0] r_now;

    // Table state
    logic [ID_W-1:0]   r_mem_ident [TABLE_DEPTH];
    logic [TIME_W-1:0] r_mem_exp   [TABLE_DEPTH];
    logic [ID_W-1:0]   r_rd_ident;
    logic [TIME_W-1:0] r_rd_exp;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;

    // Pending result and output register
    t_status           r_code;
    logic              r_banned;
    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_banned;
    logic [ENT_W-1:0]  r_out_entries;

    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_new_exp;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;
    logic              w_we;
    logic [ID_W-1:0]   w_wident;
    logic [TIME_W-1:0] w_wexp;

    // Capture the item on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_item.func;
            r_ident <= i_item.ident;
            r_dur   <= i_item.duration;
            r_now   <= i_item.now;
        end
    end

    // Expiry of a new ban, zero (never expires) for a zero duration, else saturated at the largest time value
    assign w_sum = {1'b0, r_now} + {1'b0, r_dur[TIME_W-1:0]};
    always_comb begin
        if (r_dur == '0) begin
            w_new_exp = '0;
        end else if (w_sum[TIME_W]) begin
            w_new_exp = '1;
        end else begin
            w_new_exp = w_sum[TIME_W-1:0];
        end
    end

    // Memory addresses and write data
    assign w_raddr = (i_cmd.rd_sel == RD_LAST) ? r_count[AW-1:0] : r_idx[AW-1:0];
    assign w_we    = i_cmd.wr_move | i_cmd.wr_new;
    always_comb begin
        if (i_cmd.wr_new) begin
            w_waddr  = r_hit ? r_hit_idx : r_count[AW-1:0];
            w_wident = r_ident;
            w_wexp   = w_new_exp;
        end else begin
            w_waddr  = r_idx[AW-1:0];
            w_wident = r_rd_ident;
            w_wexp   = r_rd_exp;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_ident[w_waddr] <= w_wident;
            r_mem_exp[w_waddr]   <= w_wexp;
        end
        if (i_cmd.rd_en) begin
            r_rd_ident <= r_mem_ident[w_raddr];
            r_rd_exp   <= r_mem_exp[w_raddr];
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.count_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Walk index and search hit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (i_cmd.hit_capture && o_stat.match) begin
            r_hit     <= 1'b1;
            r_hit_idx <= r_idx[AW-1:0];
        end
    end

    // Hold the result code until the result is sent
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_code) begin
            r_code   <= i_cmd.code;
            r_banned <= i_cmd.banned;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= r_code;
            r_out_banned  <= r_banned;
            r_out_entries <= ENT_W'(r_count);
        end
    end

    assign i_item.ready     = i_cmd.in_ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.status  = r_out_status;
    assign o_result.banned  = r_out_banned;
    assign o_result.entries = r_out_entries;

    // Status toward the controller
    always_comb begin
        o_stat.func     = r_func;
        o_stat.in_valid = i_item.valid;
        o_stat.out_free = !r_out_valid || o_result.ready;
        o_stat.arg_bad  = (r_ident == '0) || r_dur[DUR_W-1];
        o_stat.idx_end  = (r_idx >= r_count);
        o_stat.expired  = (r_rd_exp != '0) && (r_rd_exp <= r_now);
        o_stat.match    = (r_rd_ident == r_ident);
        o_stat.hit      = r_hit;
        o_stat.full     = (r_count >= CW'(TABLE_DEPTH));
        o_stat.empty    = (r_count == '0);
    end

endmodule

@@ sv/tblt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tblt_ctrl
// Controller: sequences purge walks, the search walk, inserts, removals
// and the result hand-off.
// ----------------------------------------------------------------------------
module tblt_ctrl
    import tblt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_final;
    logic   n_final;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_final = 1'b0;
                unique case (i_stat.func)
                    FUNC_BAN:   n_state = i_stat.arg_bad ? S_RESP : S_P_RD;
                    FUNC_UNBAN: n_state = S_S_RD;
                    FUNC_QUERY: n_state = S_P_RD;
                    default:    n_state = S_RESP;
                endcase
            end
            S_P_RD: begin
                if (i_stat.idx_end) begin
                    n_state = r_final ? S_RESP : S_S_RD;
                end else begin
                    n_state = S_P_CHK;
                end
            end
            S_P_CHK:  n_state = i_stat.expired ? S_P_MVRD : S_P_RD;
            S_P_MVRD: n_state = S_P_MVWR;
            S_P_MVWR: n_state = S_P_RD;
            S_S_RD:   n_state = i_stat.idx_end ? S_S_END : S_S_CHK;
            S_S_CHK: begin
                if (i_stat.match && (i_stat.func == FUNC_UNBAN)) begin
                    n_state = S_U_RD;
                end else begin
                    n_state = S_S_RD;
                end
            end
            S_S_END: begin
                if ((i_stat.func == FUNC_BAN) && (i_stat.hit || !i_stat.full)) begin
                    n_state = S_W_NEW;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_W_NEW: begin
                n_state = S_P_RD;
                n_final = 1'b1;
            end
            S_U_RD:  n_state = S_U_WR;
            S_U_WR: begin
                n_state = S_P_RD;
                n_final = 1'b1;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_stat.in_valid;
            end
            S_DISP: begin
                // Preset reject; later steps overwrite it unless the request is rejected
                o_cmd.set_code = 1'b1;
                o_cmd.code     = ST_REJECT;
            end
            S_P_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.idx_clr = 1'b1;
                    if (r_final) begin
                        o_cmd.set_code = 1'b1;
                        o_cmd.code     = ST_OK;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                end
            end
            S_P_CHK: begin
                // Drop an expired entry, else advance
                if (i_stat.expired) begin
                    o_cmd.count_dec = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_P_MVRD, S_U_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LAST;
            end
            S_P_MVWR: begin
                o_cmd.wr_move = 1'b1;
            end
            S_S_RD: begin
                if (!i_stat.idx_end) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                end
            end
            S_S_CHK: begin
                o_cmd.hit_capture = 1'b1;
                if (i_stat.match && (i_stat.func == FUNC_UNBAN)) begin
                    o_cmd.count_dec = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_S_END: begin
                o_cmd.set_code = 1'b1;
                unique case (i_stat.func)
                    FUNC_QUERY: begin
                        o_cmd.code   = i_stat.hit ? ST_OK : ST_NOTFOUND;
                        o_cmd.banned = i_stat.hit;
                    end
                    FUNC_BAN: begin
                        o_cmd.code = ST_FULL;
                    end
                    default: begin
                        o_cmd.code = ST_NOTFOUND;
                    end
                endcase
            end
            S_W_NEW: begin
                o_cmd.wr_new    = 1'b1;
                o_cmd.count_inc = !i_stat.hit;
                o_cmd.idx_clr   = 1'b1;
            end
            S_U_WR: begin
                o_cmd.wr_move = 1'b1;
                o_cmd.idx_clr = 1'b1;
            end
            S_RESP: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/timed_block_list_table.sv @@
// Every walk step is a read of the entry memory (registered data) followed
// by a compare; each entry removed by a purge walk adds a read and a write
// that move the last entry into its slot. One item is in work at a time.
// Reset clears the entry count and the control state; the entry memory is
// not cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
// timed_block_list_table
// Compacted table of identifiers with expiry times: ban, unban and query.
// ----------------------------------------------------------------------------
module timed_block_list_table
    import tblt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tblt_item_if.sink     i_item,
    tblt_result_if.source o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Controller
    tblt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath
    tblt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat)
    );

    // Never append to a full table
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.count_inc |-> !w_stat.full)
        else $error("entry appended to a full table");

    // Never remove from an empty table
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.count_dec |-> !w_stat.empty)
        else $error("entry removed from an empty table");

    // Take one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("second item accepted while one is in work");

    // Load a result only into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result overwritten before it was taken");

endmodule

@@ tb/tblt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblt_checker
// Watches the request and result channels of the timed block list table,
// keeps a shadow table, works out the verdict of every accepted request and
// compares each accepted result with the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tblt_checker
    import tblt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tblt_item_if   i_item,
    tblt_result_if i_result,
    output int     o_fail_count,
    output int     o_pending
);

    localparam logic [TIME_W-1:0] EXPIRY_MAX = '1;
    localparam int                REPORT_MAX = 10;

    typedef struct packed {
        t_status          status;
        logic             banned;
        logic [ENT_W-1:0] entries;
    } t_verdict;

    // Shadow copy of the table
    logic [ID_W-1:0]   shadow_ident  [TABLE_DEPTH];
    logic [TIME_W-1:0] shadow_expiry [TABLE_DEPTH];
    int                shadow_count = 0;

    t_verdict pending_verdicts[$];
    int       fail_cnt    = 0;
    int       pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // Remove one slot by moving the last entry into it
    function automatic void drop_entry(input int slot);
        shadow_count--;
        shadow_ident[slot]  = shadow_ident[shadow_count];
        shadow_expiry[slot] = shadow_expiry[shadow_count];
    endfunction

    // Drop every timed entry whose expiry is not later than the given time
    function automatic void purge_expired(input logic [TIME_W-1:0] t);
        int i;
        i = 0;
        while (i < shadow_count) begin
            if (shadow_expiry[i] != '0 && shadow_expiry[i] <= t) begin
                drop_entry(i);
            end else begin
                i++;
            end
        end
    endfunction

    // Index of the last matching entry, -1 when absent
    function automatic int find_last(input logic [ID_W-1:0] id);
        int hit;
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_ident[i] == id) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Apply one request to the shadow table and return its verdict
    function automatic t_verdict judge_request(
        input logic [FUNC_W-1:0]       func,
        input logic [ID_W-1:0]         id,
        input logic signed [DUR_W-1:0] dur,
        input logic [TIME_W-1:0]       t
    );
        t_verdict          v;
        int                idx;
        int                slot;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] expiry;
        bit                found;
        v.status = ST_REJECT;
        v.banned = 1'b0;
        case (func)
            FUNC_BAN: begin
                if (id != '0 && !dur[DUR_W-1]) begin
                    purge_expired(t);
                    idx = find_last(id);
                    if (idx < 0 && shadow_count >= TABLE_DEPTH) begin
                        v.status = ST_FULL;
                    end else begin
                        if (idx < 0) begin
                            slot = shadow_count;
                            shadow_count++;
                        end else begin
                            slot = idx;
                        end
                        expiry = '0;
                        if (dur != '0) begin
                            sum = {1'b0, t} + {1'b0, dur[TIME_W-1:0]};
                            expiry = (sum > {1'b0, EXPIRY_MAX}) ? EXPIRY_MAX : sum[TIME_W-1:0];
                        end
                        shadow_ident[slot]  = id;
                        shadow_expiry[slot] = expiry;
                        purge_expired(t);
                        v.status = ST_OK;
                    end
                end
            end
            FUNC_UNBAN: begin
                // Remove the first match only, no purge when absent
                found = 1'b0;
                for (int i = 0; i < shadow_count && !found; i++) begin
                    if (shadow_ident[i] == id) begin
                        drop_entry(i);
                        purge_expired(t);
                        found = 1'b1;
                    end
                end
                v.status = found ? ST_OK : ST_NOTFOUND;
            end
            FUNC_QUERY: begin
                purge_expired(t);
                if (find_last(id) >= 0) begin
                    v.status = ST_OK;
                    v.banned = 1'b1;
                end else begin
                    v.status = ST_NOTFOUND;
                end
            end
            default: begin
                v.status = ST_REJECT;
            end
        endcase
        v.entries = shadow_count[ENT_W-1:0];
        return v;
    endfunction

    // Count a failure, report only the first few
    function automatic void note_failure(input string what);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%0t: result error: %s", $realtime, what);
        end
    endfunction

    // Compare accepted results, then queue the verdict of an accepted request
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            shadow_count = 0;
            pending_verdicts.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (pending_verdicts.size() == 0) begin
                    note_failure($sformatf("item with none outstanding: status %0d banned %0d entries %0d",
                                           i_result.status, i_result.banned, i_result.entries));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (want.status != t_status'(i_result.status) ||
                        want.banned != i_result.banned ||
                        want.entries != i_result.entries) begin
                        note_failure($sformatf(
                            "status exp %0d got %0d, banned exp %0d got %0d, entries exp %0d got %0d",
                            want.status, i_result.status, want.banned, i_result.banned,
                            want.entries, i_result.entries));
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                pending_verdicts.push_back(judge_request(i_item.func, i_item.ident,
                                                         i_item.duration, i_item.now));
            end
        end
        pending_cnt = pending_verdicts.size();
    end

endmodule

@@ tb/timed_block_list_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_block_list_table_tb
// Drives ban, unban and query items into the timed block list table: a short
// directed list, then bursts of fills, clears, churn and noise under several
// idle and stall mixes, with a long result hold-off in two of the phases. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timed_block_list_table_tb;
    import tblt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;
    localparam int                POOL_SIZE    = 80;
    localparam int                PHASE_ITEMS  = 250;
    localparam int                HOLD_CYCLES  = 1500;
    localparam int                IDLE_LIMIT   = 20000;
    localparam int                DRAIN_CYCLES = 1000;
    localparam logic [TIME_W-1:0] TIME_MAX     = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tblt_item_if   item_ch ();
    tblt_result_if result_ch ();

    int fail_count;
    int pending;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    bit hold_start = 1'b0;

    logic [ID_W-1:0]   id_pool [POOL_SIZE];
    logic [TIME_W-1:0] cur_now = '0;

    timed_block_list_table dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    tblt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Offer one item, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_item(
        input logic [FUNC_W-1:0]       f,
        input logic [ID_W-1:0]         id,
        input logic signed [DUR_W-1:0] dur,
        input logic [TIME_W-1:0]       t
    );
        bit placed;
        placed = 1'b0;
        while (!placed) begin
            @(negedge clk);
            if ($urandom_range(99) < idle_pct) begin
                item_ch.valid <= 1'b0;
            end else begin
                item_ch.valid    <= 1'b1;
                item_ch.func     <= f;
                item_ch.ident    <= id;
                item_ch.duration <= dur;
                item_ch.now      <= t;
                placed = 1'b1;
            end
        end
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Many short bans so entries expire while the test runs
    function automatic logic signed [DUR_W-1:0] pick_duration();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) return '0;
        if (roll < 60) return $urandom_range(50, 1);
        if (roll < 72) return $urandom_range(32'h7FFF_FFFF, 0);
        if (roll < 82) return $urandom | 32'h8000_0000;
        if (roll < 87) return 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    // Advance the time stamp: small steps, rare jumps, rare rewinds, rare end of range
    task automatic advance_now();
        int          roll;
        logic [31:0] next;
        roll = $urandom_range(999);
        if (roll < 3) begin
            cur_now = TIME_MAX - TIME_W'($urandom_range(3));
        end else if (roll < 6) begin
            cur_now = TIME_W'($urandom_range(1000));
        end else begin
            next = {1'b0, cur_now} + ((roll < 30) ? $urandom_range(5000) : $urandom_range(8));
            cur_now = (next > {1'b0, TIME_MAX}) ? TIME_MAX : next[TIME_W-1:0];
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_start) begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        int                    sent;
        int                    roll;
        int                    k;
        logic [FUNC_W-1:0]     f;
        logic [ID_W-1:0]       id;
        item_ch.valid    = 1'b0;
        item_ch.func     = '0;
        item_ch.ident    = '0;
        item_ch.duration = '0;
        item_ch.now      = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = {$urandom, $urandom};
            if (id_pool[i] == '0) id_pool[i] = 64'd1;
        end

        // Hold reset low, then release it
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, bad arguments, update, saturation, expiry edges
        send_item(FUNC_QUERY, '0, '0, '0);
        send_item(FUNC_UNBAN, '1, '0, '0);
        send_item(FUNC_BAN, '0, 5, 10);
        send_item(FUNC_BAN, id_pool[0], -1, 10);
        send_item(FUNC_BAN, id_pool[0], 32'h8000_0000, 10);
        send_item(FUNC_BAN, '1, '0, 10);
        send_item(FUNC_BAN, id_pool[1], 10, 100);
        send_item(FUNC_QUERY, id_pool[1], '0, 105);
        send_item(FUNC_BAN, id_pool[1], 100, 106);
        send_item(FUNC_BAN, id_pool[2], 32'h7FFF_FFFF, TIME_MAX);
        send_item(FUNC_BAN, id_pool[3], 32'h7FFF_FFFF, 1000);
        send_item(FUNC_QUERY, id_pool[1], '0, 300);
        send_item(FUNC_UNBAN, '1, '0, 300);
        send_item(FUNC_UNBAN, id_pool[5], '0, 300);
        send_item(FUNC_SPARE, id_pool[3], 7, 300);
        send_item(FUNC_QUERY, id_pool[3], '0, TIME_MAX - TIME_W'(1));
        send_item(FUNC_QUERY, id_pool[3], '0, TIME_MAX);
        send_item(FUNC_BAN, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF, '0);
        send_item(FUNC_UNBAN, 64'h8000_0000_0000_0000, '0, 50);
        cur_now = 500;

        // Random bursts under four idle mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            // Let the block fill up behind a long result hold-off
            if (phase == 0 || phase == 2) hold_start = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 20) begin
                    // Fill: mostly long-lived bans of distinct ids, past the table size
                    for (k = 0; k < 70; k++) begin
                        advance_now();
                        send_item(FUNC_BAN, id_pool[k],
                                  $urandom_range(1) ? 32'sd0 : 32'(100000 + $urandom_range(99999)),
                                  cur_now);
                        sent++;
                    end
                end else if (roll < 35) begin
                    // Clear: unban the whole pool
                    for (k = 0; k < POOL_SIZE; k++) begin
                        advance_now();
                        send_item(FUNC_UNBAN, id_pool[k], pick_duration(), cur_now);
                        sent++;
                    end
                end else if (roll < 85) begin
                    // Churn: mixed operations on a small set of ids
                    for (k = $urandom_range(60, 30); k > 0; k--) begin
                        advance_now();
                        roll = $urandom_range(99);
                        id = id_pool[$urandom_range(23)];
                        if (roll < 45) begin
                            send_item(FUNC_BAN, id, pick_duration(), cur_now);
                        end else if (roll < 70) begin
                            send_item(FUNC_QUERY, id, pick_duration(), cur_now);
                        end else if (roll < 90) begin
                            send_item(FUNC_UNBAN, id, pick_duration(), cur_now);
                        end else begin
                            send_item(FUNC_QUERY, {$urandom, $urandom}, $urandom, cur_now);
                        end
                        sent++;
                    end
                end else begin
                    // Noise: any field value, any code
                    for (k = $urandom_range(20, 10); k > 0; k--) begin
                        f  = FUNC_W'($urandom_range(3));
                        id = ($urandom_range(9) == 0) ? '0 : {$urandom, $urandom};
                        send_item(f, id, $urandom, TIME_W'($urandom));
                        if (f != FUNC_SPARE) sent++;
                    end
                end
            end
        end

        // Drain
        @(negedge clk);
        item_ch.valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
